FILE: src/stk_pkg.sv
// ----------------------------------------------------------------------------
// Source tokenizer package
// Shared token kinds and the result record passed between the tokenizer parts.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  localparam int unsigned KindW = 5;

  localparam logic [KindW-1:0] KindEof     = 5'd0;
  localparam logic [KindW-1:0] KindId      = 5'd1;
  localparam logic [KindW-1:0] KindInt     = 5'd2;
  localparam logic [KindW-1:0] KindString  = 5'd3;
  localparam logic [KindW-1:0] KindEq      = 5'd4;
  localparam logic [KindW-1:0] KindEqEq    = 5'd5;
  localparam logic [KindW-1:0] KindSemi    = 5'd6;
  localparam logic [KindW-1:0] KindLParen  = 5'd7;
  localparam logic [KindW-1:0] KindRParen  = 5'd8;
  localparam logic [KindW-1:0] KindComma   = 5'd9;
  localparam logic [KindW-1:0] KindStar    = 5'd10;
  localparam logic [KindW-1:0] KindSlash   = 5'd11;
  localparam logic [KindW-1:0] KindPlus    = 5'd12;
  localparam logic [KindW-1:0] KindMinus   = 5'd13;
  localparam logic [KindW-1:0] KindGt      = 5'd14;
  localparam logic [KindW-1:0] KindLt      = 5'd15;
  localparam logic [KindW-1:0] KindLBrace  = 5'd16;
  localparam logic [KindW-1:0] KindRBrace  = 5'd17;
  localparam logic [KindW-1:0] KindOr      = 5'd18;
  localparam logic [KindW-1:0] KindAnd     = 5'd19;
  localparam logic [KindW-1:0] KindIf      = 5'd20;
  localparam logic [KindW-1:0] KindWhile   = 5'd21;
  localparam logic [KindW-1:0] KindFunc    = 5'd22;
  localparam logic [KindW-1:0] KindReturn  = 5'd23;
  localparam logic [KindW-1:0] KindElse    = 5'd24;
  localparam logic [KindW-1:0] KindUnterm  = 5'd25;

  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic             is_end;
    logic [KindW-1:0] kind;
    logic [7:0]       text_byte;
    logic             literal_bit;
    logic             last;
  } stk_res_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             literal_bit;
  } stk_kw_hit_t;

endpackage

`default_nettype wire

FILE: src/stk_kw_match.sv
// ----------------------------------------------------------------------------
// Keyword matcher
// Classifies a finished identifier as a keyword, a boolean literal or a name.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_kw_match import stk_pkg::*; (
  input  wire logic [47:0] kw_chars_i,
  input  wire logic [2:0]  kw_len_i,
  output stk_kw_hit_t      hit_o
);

  localparam logic [47:0] TxtOr     = {32'd0, "ro"};
  localparam logic [47:0] TxtAnd    = {24'd0, "dna"};
  localparam logic [47:0] TxtIf     = {32'd0, "fi"};
  localparam logic [47:0] TxtWhile  = {8'd0, "elihw"};
  localparam logic [47:0] TxtTrue   = {16'd0, "eurt"};
  localparam logic [47:0] TxtFalse  = {8'd0, "eslaf"};
  localparam logic [47:0] TxtFunc   = {16'd0, "cnuf"};
  localparam logic [47:0] TxtReturn = "nruter";
  localparam logic [47:0] TxtElse   = {16'd0, "esle"};

  always_comb begin
    hit_o = '{kind: KindId, literal_bit: 1'b0};
    if (kw_len_i == 3'd2 && kw_chars_i == TxtOr) begin
      hit_o.kind = KindOr;
    end else if (kw_len_i == 3'd3 && kw_chars_i == TxtAnd) begin
      hit_o.kind = KindAnd;
    end else if (kw_len_i == 3'd2 && kw_chars_i == TxtIf) begin
      hit_o.kind = KindIf;
    end else if (kw_len_i == 3'd5 && kw_chars_i == TxtWhile) begin
      hit_o.kind = KindWhile;
    end else if (kw_len_i == 3'd4 && kw_chars_i == TxtTrue) begin
      hit_o.kind        = KindInt;
      hit_o.literal_bit = 1'b1;
    end else if (kw_len_i == 3'd5 && kw_chars_i == TxtFalse) begin
      hit_o.kind = KindInt;
    end else if (kw_len_i == 3'd4 && kw_chars_i == TxtFunc) begin
      hit_o.kind = KindFunc;
    end else if (kw_len_i == 3'd6 && kw_chars_i == TxtReturn) begin
      hit_o.kind = KindReturn;
    end else if (kw_len_i == 3'd4 && kw_chars_i == TxtElse) begin
      hit_o.kind = KindElse;
    end
  end

endmodule

`default_nettype wire

FILE: src/stk_lexer.sv
// ----------------------------------------------------------------------------
// Tokenizer scan logic
// Holds the scan state and turns one request into up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_lexer import stk_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       advance_i,
  input  wire logic [7:0] char_i,
  input  wire logic       eoi_i,
  output stk_res_t        res_o [MaxRes],
  output logic [1:0]      res_n_o
);

  typedef enum logic [2:0] {
    ModeIdle,
    ModeIdent,
    ModeNumber,
    ModeString,
    ModeEquals,
    ModeHalted
  } mode_e;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [KindW-1:0] punct_kind(logic [7:0] c);
    logic [KindW-1:0] k;
    case (c)
      ";":     k = KindSemi;
      "(":     k = KindLParen;
      ")":     k = KindRParen;
      ",":     k = KindComma;
      "*":     k = KindStar;
      "/":     k = KindSlash;
      "+":     k = KindPlus;
      "-":     k = KindMinus;
      ">":     k = KindGt;
      "<":     k = KindLt;
      "{":     k = KindLBrace;
      "}":     k = KindRBrace;
      default: k = KindEof;
    endcase
    return k;
  endfunction

  function automatic stk_res_t mk_text(logic [7:0] c);
    return '{is_end: 1'b0, kind: KindEof, text_byte: c, literal_bit: 1'b0, last: 1'b0};
  endfunction

  function automatic stk_res_t mk_end(logic [KindW-1:0] k, logic lit);
    return '{is_end: 1'b1, kind: k, text_byte: 8'd0, literal_bit: lit, last: 1'b0};
  endfunction

  mode_e       mode_q, mode_d;
  logic [47:0] kw_q, kw_d;
  logic [2:0]  len_q, len_d;
  stk_kw_hit_t kw_hit;

  stk_kw_match u_kw_match (
    .kw_chars_i (kw_q),
    .kw_len_i   (len_q),
    .hit_o      (kw_hit)
  );

  // Result of starting a fresh token from the idle state.
  mode_e            si_mode;
  logic [47:0]      si_kw;
  logic [2:0]       si_len;
  logic [1:0]       si_n;
  stk_res_t         si_r0, si_r1;
  logic [KindW-1:0] pk;

  always_comb begin
    si_mode = ModeIdle;
    si_kw   = '0;
    si_len  = '0;
    si_n    = 2'd0;
    si_r0   = mk_text(char_i);
    si_r1   = mk_end(KindEof, 1'b0);
    pk      = punct_kind(char_i);
    if (char_i == " " || char_i == 8'h0d || char_i == 8'h0a) begin
      si_n = 2'd0;
    end else if (is_letter(char_i) || char_i == "_") begin
      si_n    = 2'd1;
      si_kw   = {40'd0, char_i};
      si_len  = 3'd1;
      si_mode = ModeIdent;
    end else if (is_digit(char_i)) begin
      si_n    = 2'd1;
      si_mode = ModeNumber;
    end else if (char_i == "\"") begin
      si_mode = ModeString;
    end else if (char_i == "=") begin
      si_n    = 2'd1;
      si_mode = ModeEquals;
    end else if (pk != KindEof) begin
      si_n  = 2'd2;
      si_r1 = mk_end(pk, 1'b0);
    end else begin
      si_n    = 2'd1;
      si_r0   = mk_end(KindEof, 1'b0);
      si_mode = ModeHalted;
    end
  end

  always_comb begin
    logic [1:0] idx;
    logic       take_si;
    idx     = 2'd0;
    take_si = 1'b0;
    res_o   = '{default: '0};
    mode_d  = mode_q;
    kw_d    = kw_q;
    len_d   = len_q;
    if (eoi_i) begin
      mode_d = ModeIdle;
      kw_d   = '0;
      len_d  = '0;
      unique case (mode_q)
        ModeIdent: begin
          res_o[idx] = mk_end(kw_hit.kind, kw_hit.literal_bit);
          idx = idx + 2'd1;
        end
        ModeNumber: begin
          res_o[idx] = mk_end(KindInt, 1'b0);
          idx = idx + 2'd1;
        end
        ModeString: begin
          res_o[idx] = mk_end(KindUnterm, 1'b0);
          idx = idx + 2'd1;
        end
        ModeEquals: begin
          res_o[idx] = mk_end(KindEq, 1'b0);
          idx = idx + 2'd1;
        end
        default: ;
      endcase
      if (mode_q != ModeHalted) begin
        res_o[idx] = mk_end(KindEof, 1'b0);
        idx = idx + 2'd1;
      end
    end else begin
      unique case (mode_q)
        ModeHalted: ;
        ModeIdent: begin
          if (is_letter(char_i) || is_digit(char_i) || char_i == "_") begin
            res_o[idx] = mk_text(char_i);
            idx = idx + 2'd1;
            for (int i = 0; i < 6; i++) begin
              if (len_q == 3'(i)) begin
                kw_d[8*i +: 8] = char_i;
              end
            end
            if (len_q != 3'd7) begin
              len_d = len_q + 3'd1;
            end
          end else begin
            res_o[idx] = mk_end(kw_hit.kind, kw_hit.literal_bit);
            idx = idx + 2'd1;
            take_si = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit(char_i)) begin
            res_o[idx] = mk_text(char_i);
            idx = idx + 2'd1;
          end else begin
            res_o[idx] = mk_end(KindInt, 1'b0);
            idx = idx + 2'd1;
            take_si = 1'b1;
          end
        end
        ModeString: begin
          if (char_i == "\"") begin
            res_o[idx] = mk_end(KindString, 1'b0);
            idx = idx + 2'd1;
            mode_d = ModeIdle;
          end else begin
            res_o[idx] = mk_text(char_i);
            idx = idx + 2'd1;
          end
        end
        ModeEquals: begin
          if (char_i == "=") begin
            res_o[idx] = mk_text(char_i);
            idx = idx + 2'd1;
            res_o[idx] = mk_end(KindEqEq, 1'b0);
            idx = idx + 2'd1;
            mode_d = ModeIdle;
          end else begin
            res_o[idx] = mk_end(KindEq, 1'b0);
            idx = idx + 2'd1;
            take_si = 1'b1;
          end
        end
        default: begin
          take_si = 1'b1;
        end
      endcase
      if (take_si) begin
        mode_d = si_mode;
        kw_d   = si_kw;
        len_d  = si_len;
        if (si_n != 2'd0) begin
          res_o[idx] = si_r0;
          idx = idx + 2'd1;
        end
        if (si_n == 2'd2) begin
          res_o[idx] = si_r1;
          idx = idx + 2'd1;
        end
      end
    end
    if (idx != 2'd0) begin
      res_o[idx - 2'd1].last = 1'b1;
    end
    res_n_o = idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      kw_q   <= '0;
      len_q  <= '0;
    end else if (advance_i) begin
      mode_q <= mode_d;
      kw_q   <= kw_d;
      len_q  <= len_d;
    end
  end

  a_last_of_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_n_o == 2'd3 |-> res_o[2].last && !res_o[1].last && !res_o[0].last)
    else $error("three-result request does not flag only its final result");

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeHalted |-> res_n_o == 2'd0)
    else $error("halted scanner produced a result");

  a_kw_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != ModeIdent |-> len_q == 3'd0 || mode_q == ModeString)
    else $error("identifier length left over outside an identifier");

endmodule

`default_nettype wire

FILE: src/stk_out_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Holds the results of one request and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_out_buf import stk_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire stk_res_t   res_i [MaxRes],
  input  wire logic [1:0] res_n_i,
  input  wire logic       pop_ready_i,
  output logic            valid_o,
  output stk_res_t        head_o,
  output logic            free_o
);

  stk_res_t   res_q [MaxRes];
  logic [1:0] rem_q;
  logic       pop;

  assign valid_o = rem_q != 2'd0;
  assign head_o  = res_q[0];
  assign pop     = valid_o && pop_ready_i;
  assign free_o  = rem_q == 2'd0 || (rem_q == 2'd1 && pop_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= res_n_i;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> rem_q == 2'd0 || (rem_q == 2'd1 && pop))
    else $error("result buffer loaded while results were pending");

  a_final_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd1 |-> res_q[0].last)
    else $error("final pending result is not flagged last");

  a_inner_unflagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd2 || rem_q == 2'd3 |-> !res_q[0].last)
    else $error("last flag on a result that is not final");

endmodule

`default_nettype wire

FILE: src/source_tokenizer_top.sv
// ----------------------------------------------------------------------------
// Source tokenizer
// Streaming lexer: source bytes in, token text bytes and token ends out.
//
// The slave channel takes one request per source byte; tlast marks end of
// source. The master channel gives results: a text byte of the current
// token, or a token end carrying its kind, with tlast on the final result
// caused by each request.
// A request is held in the input register; its results are then loaded into
// a three-entry result buffer once the buffer is free. The buffer hands out
// one result per cycle while the receiver is ready; a request yields at most
// three results, and the buffer drain rate sets the throughput.
// The input register takes a new request while results still wait.
// Reset returns the scanner to idle with no pending token and empties
// both registers. When the receiver stalls, the buffer holds its results
// and the slave side stops once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module source_tokenizer_top import stk_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] char_byte
  input  wire logic        s_axis_tlast_i,  // end_of_input
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [7:0] text_byte, [8] literal_bit
  output logic [5:0]       m_axis_tuser_o,  // [0] is_end, [5:1] kind
  output logic             m_axis_tlast_o   // last
);

  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_eoi_q;
  logic       advance;
  logic       buf_free;
  stk_res_t   lex_res [MaxRes];
  logic [1:0] lex_n;
  stk_res_t   head;

  assign advance         = in_vld_q && buf_free;
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
  end

  stk_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .char_i    (in_char_q),
    .eoi_i     (in_eoi_q),
    .res_o     (lex_res),
    .res_n_o   (lex_n)
  );

  stk_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (lex_res),
    .res_n_i     (lex_n),
    .pop_ready_i (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .head_o      (head),
    .free_o      (buf_free)
  );

  assign m_axis_tdata_o = {7'd0, head.literal_bit, head.text_byte};
  assign m_axis_tuser_o = {head.kind, head.is_end};
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire

FILE: tb/sv/stk_token_check.sv
// ----------------------------------------------------------------------------
// Source tokenizer token check
// Watches both stream channels of the tokenizer. For each accepted request it
// works out the token results that the request must cause and queues them.
// Each accepted result is compared field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module stk_token_check import stk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic [5:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          mismatch_cnt_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ScanIdle, ScanIdent, ScanNumber, ScanString, ScanEquals, ScanHalted
  } scan_e;

  localparam logic [KindW-1:0] NoKind = '0;
  localparam int NumKw = 9;

  string kw_word [NumKw] = '{"or", "and", "if", "while", "true", "false", "func",
                             "return", "else"};
  logic [KindW-1:0] kw_kind [NumKw] = '{KindOr, KindAnd, KindIf, KindWhile, KindInt,
                                        KindInt, KindFunc, KindReturn, KindElse};

  scan_e       scan_mode = ScanIdle;
  logic [47:0] id_chars = '0;
  logic [2:0]  id_len = '0;
  stk_res_t    token_q [$];
  stk_res_t    step_res [MaxRes];
  int          step_n;
  int          mismatches = 0;
  int          pending = 0;
  stk_res_t    got;
  stk_res_t    want;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = pending;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_token(logic is_end, logic [KindW-1:0] kind,
                                    logic [7:0] text, logic lit);
    stk_res_t r;
    r.is_end      = is_end;
    r.kind        = kind;
    r.text_byte   = text;
    r.literal_bit = lit;
    r.last        = 1'b0;
    if (step_n < MaxRes) begin
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void close_ident();
    logic [47:0] w;
    for (int k = 0; k < NumKw; k++) begin
      w = '0;
      for (int i = 0; i < kw_word[k].len(); i++) w[8*i +: 8] = kw_word[k][i];
      if (int'(id_len) == kw_word[k].len() && id_chars == w) begin
        add_token(1'b1, kw_kind[k], 8'h00, kw_word[k] == "true");
        return;
      end
    end
    add_token(1'b1, KindId, 8'h00, 1'b0);
  endfunction

  function automatic void start_token(logic [7:0] c);
    string punct = ";(),*/+-><{}";
    scan_mode = ScanIdle;
    id_chars  = '0;
    id_len    = '0;
    if (c == " " || c == 8'h0D || c == 8'h0A) return;
    if (is_letter(c) || c == "_") begin
      add_token(1'b0, NoKind, c, 1'b0);
      id_chars[7:0] = c;
      id_len        = 3'd1;
      scan_mode     = ScanIdent;
      return;
    end
    if (is_digit(c)) begin
      add_token(1'b0, NoKind, c, 1'b0);
      scan_mode = ScanNumber;
      return;
    end
    if (c == "\"") begin
      scan_mode = ScanString;
      return;
    end
    if (c == "=") begin
      add_token(1'b0, NoKind, c, 1'b0);
      scan_mode = ScanEquals;
      return;
    end
    for (int i = 0; i < punct.len(); i++) begin
      if (c == punct[i]) begin
        add_token(1'b0, NoKind, c, 1'b0);
        add_token(1'b1, KindSemi + 5'(i), 8'h00, 1'b0);
        return;
      end
    end
    add_token(1'b1, KindEof, 8'h00, 1'b0);
    scan_mode = ScanHalted;
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eoi);
    step_n = 0;
    if (eoi) begin
      case (scan_mode)
        ScanHalted: ;
        ScanIdent: begin
          close_ident();
          add_token(1'b1, KindEof, 8'h00, 1'b0);
        end
        ScanNumber: begin
          add_token(1'b1, KindInt, 8'h00, 1'b0);
          add_token(1'b1, KindEof, 8'h00, 1'b0);
        end
        ScanString: begin
          add_token(1'b1, KindUnterm, 8'h00, 1'b0);
          add_token(1'b1, KindEof, 8'h00, 1'b0);
        end
        ScanEquals: begin
          add_token(1'b1, KindEq, 8'h00, 1'b0);
          add_token(1'b1, KindEof, 8'h00, 1'b0);
        end
        default: add_token(1'b1, KindEof, 8'h00, 1'b0);
      endcase
      scan_mode = ScanIdle;
      id_chars  = '0;
      id_len    = '0;
    end else begin
      case (scan_mode)
        ScanHalted: ;
        ScanIdent: begin
          if (is_letter(c) || is_digit(c) || c == "_") begin
            add_token(1'b0, NoKind, c, 1'b0);
            if (id_len < 3'd6) id_chars[8*id_len +: 8] = c;
            if (id_len < 3'd7) id_len++;
          end else begin
            close_ident();
            start_token(c);
          end
        end
        ScanNumber: begin
          if (is_digit(c)) begin
            add_token(1'b0, NoKind, c, 1'b0);
          end else begin
            add_token(1'b1, KindInt, 8'h00, 1'b0);
            start_token(c);
          end
        end
        ScanString: begin
          if (c == "\"") begin
            add_token(1'b1, KindString, 8'h00, 1'b0);
            scan_mode = ScanIdle;
          end else begin
            add_token(1'b0, NoKind, c, 1'b0);
          end
        end
        ScanEquals: begin
          if (c == "=") begin
            add_token(1'b0, NoKind, c, 1'b0);
            add_token(1'b1, KindEqEq, 8'h00, 1'b0);
            scan_mode = ScanIdle;
          end else begin
            add_token(1'b1, KindEq, 8'h00, 1'b0);
            start_token(c);
          end
        end
        default: start_token(c);
      endcase
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_res[i]);
  endfunction

  function automatic void compare_field(string name, int exp, int act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode = ScanIdle;
      id_chars  = '0;
      id_len    = '0;
      token_q.delete();
      pending   = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.is_end      = m_tuser_i[0];
        got.kind        = m_tuser_i[5:1];
        got.text_byte   = m_tdata_i[7:0];
        got.literal_bit = m_tdata_i[8];
        got.last        = m_tlast_i;
        if (token_q.size() == 0) begin
          $error("result with none expected: is_end %0d kind %0d text_byte %0d",
                 got.is_end, got.kind, got.text_byte);
          mismatches++;
        end else begin
          want = token_q.pop_front();
          compare_field("is_end", want.is_end, got.is_end);
          compare_field("kind", want.kind, got.kind);
          compare_field("text_byte", want.text_byte, got.text_byte);
          compare_field("literal_bit", want.literal_bit, got.literal_bit);
          compare_field("last", want.last, got.last);
        end
      end
      if (s_tvalid_i && s_tready_i) lex_step(s_tdata_i, s_tlast_i);
      pending = token_q.size();
    end
  end

endmodule

FILE: tb/sv/source_tokenizer_top_tb.sv
// ----------------------------------------------------------------------------
// Source tokenizer testbench
// Feeds the tokenizer a directed byte sequence of corner cases, then random
// well-formed token streams mixed with noise.
// Both sides idle at random in two of three phases; the receiver also holds off for
// a long stretch once. The token check module predicts and compares results.
// ----------------------------------------------------------------------------
module source_tokenizer_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [5:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int          mismatch_cnt;
  int          pending;
  int          src_idle_pct = 31;
  int          sink_idle_pct = 66;
  int          fed = 0;
  int unsigned cycle_cnt = 0;
  bit          stall_sink = 1'b0;
  bit          stall_done = 1'b0;
  int          stall_left = 0;

  string words [16] = '{"or", "and", "if", "while", "true", "false", "func", "return",
                        "else", "iff", "els", "returns", "whilex", "truex", "falsey",
                        "func_"};

  always #2 clk_i = ~clk_i;

  source_tokenizer_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  stk_token_check i_token_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid_i),
    .s_tready_i     (s_axis_tready_o),
    .s_tdata_i      (s_axis_tdata_i),
    .s_tlast_i      (s_axis_tlast_i),
    .m_tvalid_i     (m_axis_tvalid_o),
    .m_tready_i     (m_axis_tready_i),
    .m_tdata_i      (m_axis_tdata_o),
    .m_tuser_i      (m_axis_tuser_o),
    .m_tlast_i      (m_axis_tlast_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("** source_tokenizer_top: FAILED **");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block fills up.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (stall_sink && !stall_done) begin
      stall_left      <= HoldCycles;
      stall_done      <= 1'b1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_request(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    s_axis_tlast_i  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    fed++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic send_eoi();
    send_request(8'($urandom_range(255)), 1'b1);
  endtask

  function automatic logic [7:0] word_char(bit first);
    int sel;
    sel = first ? $urandom_range(2) : $urandom_range(3);
    case (sel)
      0: return 8'("a" + $urandom_range(25));
      1: return 8'("A" + $urandom_range(25));
      2: return "_";
      default: return 8'("0" + $urandom_range(9));
    endcase
  endfunction

  task automatic send_random_token();
    int pick;
    int len;
    logic [7:0] c;
    string punct;
    punct = ";(),*/+-><{}";
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_text(words[$urandom_range(15)]);
    end else if (pick < 30) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 5);
      send_request(word_char(1'b1), 1'b0);
      for (int i = 1; i < len; i++) send_request(word_char(1'b0), 1'b0);
    end else if (pick < 42) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) send_request(8'("0" + $urandom_range(9)), 1'b0);
    end else if (pick < 54) begin
      send_request("\"", 1'b0);
      len = $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        do c = 8'($urandom_range(255)); while (c == "\"");
        send_request(c, 1'b0);
      end
      if ($urandom_range(9) == 0) send_eoi();
      else send_request("\"", 1'b0);
    end else if (pick < 62) begin
      if ($urandom_range(1) == 0) send_text("=");
      else send_text("==");
    end else if (pick < 78) begin
      send_request(punct[$urandom_range(11)], 1'b0);
    end else if (pick < 90) begin
      case ($urandom_range(2))
        0: send_request(" ", 1'b0);
        1: send_request(8'h0D, 1'b0);
        default: send_request(8'h0A, 1'b0);
      endcase
    end else if (pick < 95) begin
      send_eoi();
    end else begin
      // Noise byte; an end of source follows so a halted block recovers.
      send_request(8'($urandom_range(255)), 1'b0);
      send_eoi();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("_z9 7a==\"\"\"");
    send_request(8'hFF, 1'b0);
    send_request(8'h0D, 1'b0);
    send_request(8'h00, 1'b0);
    send_text("\"=");
    send_eoi();
    send_text("\"x");
    send_eoi();
    send_request("9", 1'b0);
    send_request(8'h09, 1'b0);
    send_request("q", 1'b0);
    send_eoi();

    while (fed < 80) send_random_token();
    src_idle_pct  = 66;
    sink_idle_pct = 31;
    while (fed < 130) send_random_token();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    stall_sink    = 1'b1;
    while (fed < 180) send_random_token();
    send_eoi();
    s_axis_tvalid_i <= 1'b0;

    do begin
      while (pending != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
    end while (pending != 0);

    if (mismatch_cnt == 0) begin
      $display("** source_tokenizer_top: PASSED **");
    end else begin
      $display("** source_tokenizer_top: FAILED **");
    end
    $finish;
  end

endmodule
